// File: hw/rtl/fsnh_pkg.sv
// Shared types and constants for the frame scaler.
// No dependencies; imported by every module of the block.
package fsnh_pkg;

    localparam int unsigned PIX_W    = 24;
    localparam int unsigned CH_W     = 8;
    localparam int unsigned COORD_W  = 9;
    localparam int unsigned STRIDE_W = 10;
    localparam int unsigned RATIO_W  = 25;
    localparam int unsigned FRAC_W   = 16;
    localparam int unsigned POS_W    = COORD_W + RATIO_W;
    localparam int unsigned IDX_W    = POS_W - FRAC_W;
    localparam int unsigned PROD_W   = IDX_W + STRIDE_W;
    localparam int unsigned LIN_W    = PROD_W + 1;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned N_STAGES = 7;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [2:0] {
        REG_ROW_STRIDE = 3'd0,
        REG_X_RATIO    = 3'd1,
        REG_Y_RATIO    = 3'd2,
        REG_SKIP_COLS  = 3'd3,
        REG_SKIP_ROWS  = 3'd4,
        REG_BLUR_EN    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [STRIDE_W-1:0] row_stride;
        logic [RATIO_W-1:0]  x_ratio;
        logic [RATIO_W-1:0]  y_ratio;
        logic [COORD_W-1:0]  skip_cols;
        logic [COORD_W-1:0]  skip_rows;
    } t_cfg;

    // address stage -> store stage
    typedef struct packed {
        logic              mode;
        logic [LIN_W-1:0]  lin;
        logic              a_oob;
        logic              b_oob;
        logic [FRAC_W-1:0] mu;
        logic [PIX_W-1:0]  pixel;
    } t_mem_req;

    // store stage -> blend stage
    typedef struct packed {
        logic              mode;
        logic              a_oob;
        logic              b_oob;
        logic [FRAC_W-1:0] mu;
    } t_rd_info;

endpackage

// File: hw/rtl/frame_scaler_nearest_hlerp.sv
// Top level of the frame scaler: APB register file, stage valid chain, submodules.
// Depends on fsnh_pkg, fsnh_addr, fsnh_store and fsnh_blend.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------
//  input    | i_in_valid / o_in_ready  | i_mode, i_col, i_row, i_pixel
//  output   | o_out_valid / i_out_ready| o_out_pixel
//  config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// Seven register stages; one transaction per cycle while the output is not stalled;
// a read's result is offered from the stage 7 register.
// Two ratio multipliers, one row-stride multiplier and a dual-read frame store
// set the stage split. Writes leave the pipe at the store stage with no result.
// Each stage holds while its successor is full and stalled; empty stages fill.
// Synchronous active-low reset clears valid bits and loads register-file defaults; store is unset.
module frame_scaler_nearest_hlerp #(
    parameter int unsigned MAX_WIDTH  = 512,
    parameter int unsigned MAX_HEIGHT = 512
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic [fsnh_pkg::COORD_W-1:0] i_col,
    input  logic [fsnh_pkg::COORD_W-1:0] i_row,
    input  logic [fsnh_pkg::PIX_W-1:0]   i_pixel,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [31:0]                  o_out_pixel,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fsnh_pkg::APB_AW-1:0]  paddr,
    input  logic [fsnh_pkg::APB_DW-1:0]  pwdata,
    output logic [fsnh_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);
    import fsnh_pkg::*;

    localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW    = $clog2(DEPTH);

    t_cfg                r_cfg;
    logic                r_blur;
    logic [N_STAGES:1]   r_vld;
    logic [N_STAGES:1]   n_en;
    t_reg_idx            n_idx;
    t_mem_req            w_req;
    logic [PIX_W-1:0]    w_a;
    logic [PIX_W-1:0]    w_b;
    t_rd_info            w_info;

    assign pready = 1'b1;
    assign n_idx  = t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_stride <= STRIDE_W'(256);
            r_cfg.x_ratio    <= RATIO_W'(65536);
            r_cfg.y_ratio    <= RATIO_W'(65536);
            r_cfg.skip_cols  <= '0;
            r_cfg.skip_rows  <= '0;
            r_blur           <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            unique case (n_idx)
                REG_ROW_STRIDE: r_cfg.row_stride <= pwdata[STRIDE_W-1:0];
                REG_X_RATIO:    r_cfg.x_ratio    <= pwdata[RATIO_W-1:0];
                REG_Y_RATIO:    r_cfg.y_ratio    <= pwdata[RATIO_W-1:0];
                REG_SKIP_COLS:  r_cfg.skip_cols  <= pwdata[COORD_W-1:0];
                REG_SKIP_ROWS:  r_cfg.skip_rows  <= pwdata[COORD_W-1:0];
                REG_BLUR_EN:    r_blur           <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (n_idx)
            REG_ROW_STRIDE: prdata = APB_DW'(r_cfg.row_stride);
            REG_X_RATIO:    prdata = APB_DW'(r_cfg.x_ratio);
            REG_Y_RATIO:    prdata = APB_DW'(r_cfg.y_ratio);
            REG_SKIP_COLS:  prdata = APB_DW'(r_cfg.skip_cols);
            REG_SKIP_ROWS:  prdata = APB_DW'(r_cfg.skip_rows);
            REG_BLUR_EN:    prdata = APB_DW'(r_blur);
            default:        prdata = '0;
        endcase
    end

    // a stage loads when empty or when its successor moves on
    always_comb begin
        n_en[N_STAGES] = !r_vld[N_STAGES] || i_out_ready;
        for (int k = N_STAGES - 1; k >= 1; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 1; k <= N_STAGES; k++) begin
                if (n_en[k]) begin
                    priority if (k == 1) begin
                        r_vld[k] <= i_in_valid;
                    end else if (k == 6) begin
                        r_vld[k] <= r_vld[k-1] && w_info.mode;
                    end else begin
                        r_vld[k] <= r_vld[k-1];
                    end
                end
            end
        end
    end

    assign o_in_ready  = n_en[1];
    assign o_out_valid = r_vld[N_STAGES];

    fsnh_addr #(
        .DEPTH(DEPTH)
    ) u_addr (
        .i_clk  (i_clk),
        .i_en   (n_en[4:1]),
        .i_cfg  (r_cfg),
        .i_mode (i_mode),
        .i_col  (i_col),
        .i_row  (i_row),
        .i_pixel(i_pixel),
        .o_req  (w_req)
    );

    fsnh_store #(
        .DEPTH(DEPTH),
        .AW   (AW)
    ) u_store (
        .i_clk (i_clk),
        .i_en  (n_en[5]),
        .i_vld (r_vld[4]),
        .i_req (w_req),
        .o_a   (w_a),
        .o_b   (w_b),
        .o_info(w_info)
    );

    fsnh_blend u_blend (
        .i_clk  (i_clk),
        .i_en   (n_en[7:6]),
        .i_blur (r_blur),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_info (w_info),
        .o_pixel(o_out_pixel)
    );

endmodule

// File: hw/rtl/fsnh_addr.sv
// Address pipeline: ratio products, crop offsets, row product, linear address.
// Stages 1 to 4. Depends on fsnh_pkg.
module fsnh_addr #(
    parameter int unsigned DEPTH = 262144
) (
    input  logic                       i_clk,
    input  logic [4:1]                 i_en,
    input  fsnh_pkg::t_cfg             i_cfg,
    input  logic                       i_mode,
    input  logic [fsnh_pkg::COORD_W-1:0] i_col,
    input  logic [fsnh_pkg::COORD_W-1:0] i_row,
    input  logic [fsnh_pkg::PIX_W-1:0] i_pixel,
    output fsnh_pkg::t_mem_req         o_req
);
    import fsnh_pkg::*;

    logic                r1_mode;
    logic [COORD_W-1:0]  r1_col;
    logic [COORD_W-1:0]  r1_row;
    logic [PIX_W-1:0]    r1_pixel;
    logic [POS_W-1:0]    r1_xpos;
    logic [POS_W-1:0]    r1_ypos;

    logic                r2_mode;
    logic [IDX_W-1:0]    r2_rsum;
    logic [IDX_W-1:0]    r2_csum;
    logic [FRAC_W-1:0]   r2_mu;
    logic [PIX_W-1:0]    r2_pixel;

    logic                r3_mode;
    logic [PROD_W-1:0]   r3_prod;
    logic [IDX_W-1:0]    r3_csum;
    logic [FRAC_W-1:0]   r3_mu;
    logic [PIX_W-1:0]    r3_pixel;

    t_mem_req            r4_req;

    logic [IDX_W:0]      n_rsum;
    logic [IDX_W:0]      n_csum;
    logic [LIN_W-1:0]    n_lin;

    // sums can exceed 2**IDX_W - 1; only their low IDX_W bits are registered
    always_comb begin
        if (r1_mode) begin
            n_rsum = (IDX_W+1)'(i_cfg.skip_rows) + (IDX_W+1)'(r1_ypos[POS_W-1:FRAC_W]);
            n_csum = (IDX_W+1)'(i_cfg.skip_cols) + (IDX_W+1)'(r1_xpos[POS_W-1:FRAC_W]);
        end else begin
            n_rsum = (IDX_W+1)'(r1_row);
            n_csum = (IDX_W+1)'(r1_col);
        end
        n_lin = LIN_W'(r3_prod) + LIN_W'(r3_csum);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r1_mode  <= i_mode;
            r1_col   <= i_col;
            r1_row   <= i_row;
            r1_pixel <= i_pixel;
            r1_xpos  <= POS_W'(i_col) * POS_W'(i_cfg.x_ratio);
            r1_ypos  <= POS_W'(i_row) * POS_W'(i_cfg.y_ratio);
        end
        if (i_en[2]) begin
            r2_mode  <= r1_mode;
            r2_rsum  <= n_rsum[IDX_W-1:0];
            r2_csum  <= n_csum[IDX_W-1:0];
            r2_mu    <= r1_xpos[FRAC_W-1:0];
            r2_pixel <= r1_pixel;
        end
        if (i_en[3]) begin
            r3_mode  <= r2_mode;
            r3_prod  <= PROD_W'(r2_rsum) * PROD_W'(i_cfg.row_stride);
            r3_csum  <= r2_csum;
            r3_mu    <= r2_mu;
            r3_pixel <= r2_pixel;
        end
        if (i_en[4]) begin
            r4_req.mode  <= r3_mode;
            r4_req.lin   <= n_lin;
            r4_req.a_oob <= (n_lin >= LIN_W'(DEPTH));
            r4_req.b_oob <= (n_lin >= LIN_W'(DEPTH - 1));
            r4_req.mu    <= r3_mu;
            r4_req.pixel <= r3_pixel;
        end
    end

    assign o_req = r4_req;

endmodule

// File: hw/rtl/fsnh_store.sv
// Source frame store: one write port, two registered read ports (pixel and next).
// Stage 5. Depends on fsnh_pkg.
module fsnh_store #(
    parameter int unsigned DEPTH = 262144,
    parameter int unsigned AW    = 18
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  fsnh_pkg::t_mem_req         i_req,
    output logic [fsnh_pkg::PIX_W-1:0] o_a,
    output logic [fsnh_pkg::PIX_W-1:0] o_b,
    output fsnh_pkg::t_rd_info         o_info
);
    import fsnh_pkg::*;

    logic [PIX_W-1:0] r_mem [DEPTH];
    logic [PIX_W-1:0] r_a;
    logic [PIX_W-1:0] r_b;
    t_rd_info         r_info;
    logic [AW-1:0]    n_addr_a;
    logic [AW-1:0]    n_addr_b;

    assign n_addr_a = i_req.lin[AW-1:0];
    assign n_addr_b = n_addr_a + AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_vld && !i_req.mode && !i_req.a_oob) begin
                r_mem[n_addr_a] <= i_req.pixel;
            end
            r_a          <= r_mem[n_addr_a];
            r_b          <= r_mem[n_addr_b];
            r_info.mode  <= i_req.mode;
            r_info.a_oob <= i_req.a_oob;
            r_info.b_oob <= i_req.b_oob;
            r_info.mu    <= i_req.mu;
        end
    end

    assign o_a    = r_a;
    assign o_b    = r_b;
    assign o_info = r_info;

endmodule

// File: hw/rtl/fsnh_blend.sv
// Horizontal blend: per-channel difference times fraction, then add and pack ARGB.
// Stages 6 and 7. Depends on fsnh_pkg.
module fsnh_blend (
    input  logic                       i_clk,
    input  logic [7:6]                 i_en,
    input  logic                       i_blur,
    input  logic [fsnh_pkg::PIX_W-1:0] i_a,
    input  logic [fsnh_pkg::PIX_W-1:0] i_b,
    input  fsnh_pkg::t_rd_info         i_info,
    output logic [31:0]                o_pixel
);
    import fsnh_pkg::*;

    localparam int unsigned N_CH = PIX_W / CH_W;
    localparam int unsigned MUL_W = CH_W + 1 + FRAC_W + 1;

    logic [PIX_W-1:0]        n_a;
    logic [PIX_W-1:0]        n_b;
    logic [FRAC_W-1:0]       n_mu;
    logic signed [CH_W:0]    n_d   [N_CH];
    logic signed [MUL_W-1:0] n_p   [N_CH];
    logic [PIX_W-1:0]        n_rgb;

    logic [PIX_W-1:0]        r6_a;
    logic signed [MUL_W-1:0] r6_p  [N_CH];
    logic [31:0]             r7_pixel;

    // the next pixel plays no part in nearest mode
    always_comb begin
        n_a  = i_info.a_oob ? '0 : i_a;
        n_b  = (i_info.b_oob || !i_blur) ? '0 : i_b;
        n_mu = i_blur ? i_info.mu : '0;
        for (int c = 0; c < N_CH; c++) begin
            n_d[c] = $signed({1'b0, n_b[c*CH_W +: CH_W]})
                   - $signed({1'b0, n_a[c*CH_W +: CH_W]});
            n_p[c] = MUL_W'(n_d[c]) * $signed({1'b0, n_mu});
        end
    end

    // a + floor(d*mu / 2^16); the result always fits a channel
    always_comb begin
        for (int c = 0; c < N_CH; c++) begin
            n_rgb[c*CH_W +: CH_W] = r6_a[c*CH_W +: CH_W] + r6_p[c][FRAC_W +: CH_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r6_a <= n_a;
            for (int c = 0; c < N_CH; c++) begin
                r6_p[c] <= n_p[c];
            end
        end
        if (i_en[7]) begin
            r7_pixel <= {ALPHA_OPAQUE, n_rgb};
        end
    end

    assign o_pixel = r7_pixel;

endmodule
